// ===== hdl/ppmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppmfd_pkg
// Shared types and constants for the PPM frame decoder.
// ----------------------------------------------------------------------------
package ppmfd_pkg;

    localparam int TIME_W           = 16;
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int MAX_CHANNELS_HI  = 32;
    localparam int RUN_W            = $clog2(MAX_CHANNELS_HI + 1);
    localparam int LOCK_W           = 5;
    localparam int IDX_W            = 4;
    localparam int SETTLE_W         = 4;
    localparam int CFG_ADDR_W       = 3;
    localparam int CFG_DATA_W       = 16;
    localparam int QUEUE_DEPTH      = 4;

    // register map
    localparam logic [CFG_ADDR_W-1:0] REG_START_GAP_MIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_WIDTH_MIN   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_WIDTH_MAX   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_VALUE_MIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_VALUE_MAX = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_CHANNELS      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_LOCK_FRAMES       = 3'd6;

    // register reset values
    localparam logic [TIME_W-1:0]   RST_START_GAP_MIN     = 16'd2300;
    localparam logic [TIME_W-1:0]   RST_PULSE_WIDTH_MIN   = 16'd200;
    localparam logic [TIME_W-1:0]   RST_PULSE_WIDTH_MAX   = 16'd600;
    localparam logic [TIME_W-1:0]   RST_CHANNEL_VALUE_MIN = 16'd800;
    localparam logic [TIME_W-1:0]   RST_CHANNEL_VALUE_MAX = 16'd2200;
    localparam logic [LOCK_W-1:0]   RST_MIN_CHANNELS      = 5'd5;
    localparam logic [SETTLE_W-1:0] RST_LOCK_FRAMES       = 4'd4;

    typedef enum logic [1:0] {
        PH_UNSYNC   = 2'd0,
        PH_ARM      = 2'd1,
        PH_ACTIVE   = 2'd2,
        PH_INACTIVE = 2'd3
    } phase_t;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic               publish;
        logic [RUN_W-1:0]   run_len;
        logic [LOCK_W-1:0]  locked;
        logic [TIME_W-1:0]  frame_ticks;
        phase_t             phase;
    } job_t;

endpackage

// ===== hdl/ppmfd_queue.sv =====
// ----------------------------------------------------------------------------
// ppmfd_queue
// Small register FIFO of jobs between the edge classifier and the emitter.
// ----------------------------------------------------------------------------
module ppmfd_queue #(
    parameter int DEPTH = ppmfd_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ppmfd_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output ppmfd_pkg::job_t   head_job,
    output logic              empty
);
    import ppmfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/ppmfd_front.sv =====
// ----------------------------------------------------------------------------
// ppmfd_front
// Edge classifier: config registers, phase tracking, window checks, count
// settling; writes channel values and queues one job per edge word.
// ----------------------------------------------------------------------------
module ppmfd_front #(
    parameter int MAX_CHANNELS = ppmfd_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // config
    input  logic                                 cfg_we,
    input  logic [ppmfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // edge words
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ppmfd_pkg::TIME_W-1:0]         edge_time,
    input  logic                                 capture_overflow,
    // channel store write port
    output logic                                 mem_we,
    output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] mem_addr,
    output logic [ppmfd_pkg::TIME_W-1:0]         mem_wdata,
    // job queue
    output logic                                 job_push,
    output ppmfd_pkg::job_t                      job,
    input  logic                                 queue_full,
    input  logic                                 run_done
);
    import ppmfd_pkg::*;

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // config registers
    logic [TIME_W-1:0]   start_gap_min_reg, pulse_width_min_reg, pulse_width_max_reg;
    logic [TIME_W-1:0]   channel_value_min_reg, channel_value_max_reg;
    logic [LOCK_W-1:0]   min_channels_reg;
    logic [SETTLE_W-1:0] lock_frames_reg;

    // decoder state
    phase_t              phase_reg, phase_next;
    logic [TIME_W-1:0]   prev_edge_reg, prev_edge_next;
    logic [TIME_W-1:0]   prev_mark_reg, prev_mark_next;
    logic [TIME_W-1:0]   frame_origin_reg, frame_origin_next;
    logic [TIME_W-1:0]   frame_len_reg, frame_len_next;
    logic [CNT_W-1:0]    pending_reg, pending_next;
    logic [CNT_W-1:0]    locked_reg, locked_next;
    logic [CNT_W-1:0]    cand_reg, cand_next;
    logic [SETTLE_W-1:0] settle_reg, settle_next;
    logic                busy_reg, busy_next;

    logic                accept;
    logic                emit;
    logic [TIME_W-1:0]   width, interval;
    logic                pulse_ok, value_ok;

    assign s_tready = !busy_reg && !queue_full;
    assign accept   = s_tvalid && s_tready;

    assign width    = edge_time - prev_edge_reg;
    assign interval = edge_time - prev_mark_reg;
    assign pulse_ok = (width >= pulse_width_min_reg) && (width <= pulse_width_max_reg);
    assign value_ok = (interval >= channel_value_min_reg)
                   && (interval <= channel_value_max_reg);

    always_comb begin
        phase_next        = phase_reg;
        prev_edge_next    = prev_edge_reg;
        prev_mark_next    = prev_mark_reg;
        frame_origin_next = frame_origin_reg;
        frame_len_next    = frame_len_reg;
        pending_next      = pending_reg;
        locked_next       = locked_reg;
        cand_next         = cand_reg;
        settle_next       = settle_reg;
        emit              = 1'b0;
        mem_we            = 1'b0;
        mem_addr          = pending_reg[AW-1:0];
        mem_wdata         = interval;

        if (capture_overflow) begin
            phase_next  = PH_UNSYNC;
            locked_next = '0;
        end else if (width >= start_gap_min_reg) begin
            if (pending_reg != locked_reg) begin
                if (cand_reg != pending_reg) begin
                    cand_next   = pending_reg;
                    settle_next = lock_frames_reg;
                end else if (settle_reg != '0) begin
                    settle_next = settle_reg - 1'b1;
                end else begin
                    locked_next = cand_reg;
                    cand_next   = '0;
                end
            end else if (RUN_W'(pending_reg) > RUN_W'(min_channels_reg)) begin
                emit = 1'b1;
            end
            pending_next   = '0;
            phase_next     = PH_ARM;
            prev_edge_next = edge_time;
        end else begin
            case (phase_reg)
                PH_ARM: begin
                    if (!pulse_ok) begin
                        phase_next  = PH_UNSYNC;
                        locked_next = '0;
                    end else begin
                        prev_mark_next    = prev_edge_reg;
                        frame_len_next    = prev_edge_reg - frame_origin_reg;
                        frame_origin_next = prev_edge_reg;
                        phase_next        = PH_ACTIVE;
                        prev_edge_next    = edge_time;
                    end
                end
                PH_INACTIVE: begin
                    if (!pulse_ok) begin
                        phase_next  = PH_UNSYNC;
                        locked_next = '0;
                    end else begin
                        phase_next     = PH_ACTIVE;
                        prev_edge_next = edge_time;
                    end
                end
                PH_ACTIVE: begin
                    // mark moves even when the interval is rejected
                    prev_mark_next = edge_time;
                    if (!value_ok) begin
                        phase_next  = PH_UNSYNC;
                        locked_next = '0;
                    end else begin
                        if (pending_reg < CNT_W'(MAX_CHANNELS)) begin
                            mem_we       = accept;
                            pending_next = pending_reg + 1'b1;
                        end
                        phase_next     = PH_INACTIVE;
                        prev_edge_next = edge_time;
                    end
                end
                default: begin
                    prev_edge_next = edge_time;
                end
            endcase
        end

        busy_next = busy_reg;
        if (run_done) begin
            busy_next = 1'b0;
        end
        if (accept && emit) begin
            busy_next = 1'b1;
        end
    end

    assign job_push         = accept;
    assign job.publish      = emit;
    assign job.run_len      = RUN_W'(pending_reg);
    assign job.locked       = LOCK_W'(locked_next);
    assign job.frame_ticks  = frame_len_next;
    assign job.phase        = phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_gap_min_reg     <= RST_START_GAP_MIN;
            pulse_width_min_reg   <= RST_PULSE_WIDTH_MIN;
            pulse_width_max_reg   <= RST_PULSE_WIDTH_MAX;
            channel_value_min_reg <= RST_CHANNEL_VALUE_MIN;
            channel_value_max_reg <= RST_CHANNEL_VALUE_MAX;
            min_channels_reg      <= RST_MIN_CHANNELS;
            lock_frames_reg       <= RST_LOCK_FRAMES;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_START_GAP_MIN:     start_gap_min_reg     <= cfg_wdata;
                REG_PULSE_WIDTH_MIN:   pulse_width_min_reg   <= cfg_wdata;
                REG_PULSE_WIDTH_MAX:   pulse_width_max_reg   <= cfg_wdata;
                REG_CHANNEL_VALUE_MIN: channel_value_min_reg <= cfg_wdata;
                REG_CHANNEL_VALUE_MAX: channel_value_max_reg <= cfg_wdata;
                REG_MIN_CHANNELS:      min_channels_reg      <= cfg_wdata[LOCK_W-1:0];
                REG_LOCK_FRAMES:       lock_frames_reg       <= cfg_wdata[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_UNSYNC;
            prev_edge_reg    <= '0;
            prev_mark_reg    <= '0;
            frame_origin_reg <= '0;
            frame_len_reg    <= '0;
            pending_reg      <= '0;
            locked_reg       <= '0;
            cand_reg         <= '0;
            settle_reg       <= '0;
            busy_reg         <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            if (accept) begin
                phase_reg        <= phase_next;
                prev_edge_reg    <= prev_edge_next;
                prev_mark_reg    <= prev_mark_next;
                frame_origin_reg <= frame_origin_next;
                frame_len_reg    <= frame_len_next;
                pending_reg      <= pending_next;
                locked_reg       <= locked_next;
                cand_reg         <= cand_next;
                settle_reg       <= settle_next;
            end
        end
    end

endmodule

// ===== hdl/ppmfd_back.sv =====
// ----------------------------------------------------------------------------
// ppmfd_back
// Result emitter: holds the channel store, pops jobs and drives result words,
// one status word or a run of channel words per job.
// ----------------------------------------------------------------------------
module ppmfd_back #(
    parameter int MAX_CHANNELS = ppmfd_pkg::DEF_MAX_CHANNELS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // channel store write port
    input  logic                                 mem_we,
    input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] mem_addr,
    input  logic [ppmfd_pkg::TIME_W-1:0]         mem_wdata,
    // job queue
    input  ppmfd_pkg::job_t                      head_job,
    input  logic                                 queue_empty,
    output logic                                 job_pop,
    output logic                                 run_done,
    // result words
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic                                 out_publish,
    output logic                                 out_last,
    output logic [ppmfd_pkg::IDX_W-1:0]          out_index,
    output logic [ppmfd_pkg::TIME_W-1:0]         out_value,
    output logic [ppmfd_pkg::LOCK_W-1:0]         out_locked,
    output logic [ppmfd_pkg::TIME_W-1:0]         out_frame_ticks,
    output logic [1:0]                           out_phase
);
    import ppmfd_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SHOW
    } state_t;

    logic [TIME_W-1:0] store_mem [MAX_CHANNELS];

    state_t            state_reg;
    job_t              job_reg;
    logic [AW-1:0]     idx_reg;
    logic [TIME_W-1:0] rd_data_reg;
    logic              last_reg;
    logic              done_reg;

    assign job_pop  = (state_reg == ST_IDLE) && !queue_empty;
    assign run_done = done_reg;

    assign m_tvalid        = (state_reg == ST_SHOW);
    assign out_publish     = job_reg.publish;
    assign out_last        = last_reg;
    assign out_index       = job_reg.publish ? IDX_W'(idx_reg) : '0;
    assign out_value       = job_reg.publish ? rd_data_reg : '0;
    assign out_locked      = job_reg.locked;
    assign out_frame_ticks = job_reg.frame_ticks;
    assign out_phase       = job_reg.phase;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (state_reg == ST_FETCH) begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            job_reg   <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (!queue_empty) begin
                        job_reg <= head_job;
                        idx_reg <= '0;
                        if (head_job.publish) begin
                            state_reg <= ST_FETCH;
                        end else begin
                            last_reg  <= 1'b1;
                            state_reg <= ST_SHOW;
                        end
                    end
                end
                ST_FETCH: begin
                    last_reg  <= ((RUN_W'(idx_reg) + RUN_W'(1)) == job_reg.run_len);
                    state_reg <= ST_SHOW;
                end
                ST_SHOW: begin
                    if (m_tready) begin
                        if (last_reg) begin
                            done_reg  <= job_reg.publish;
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_FETCH;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/ppm_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// ppm_frame_decoder
// RC pulse-position frame decoder: classifies captured edge times, tracks the
// channel count and emits channel runs or status words.
// ----------------------------------------------------------------------------
// Order: once its edge word is taken, a job is registered in the queue, then
//   loaded by an idle emitter; a status word is then shown, a channel run word only after a store read.
// Throughput: the emitter loads each status job before showing its word, so edge
//   words go in one a cycle only until the 4-deep job queue fills; a published frame
//   is emitted as a job load, then a store read plus output per word, and the input
//   stalls until after its last word is taken.
// Reset: aresetn is synchronous, active low; it loads the register defaults,
//   clears phase, counters and queue. The channel store is not cleared.
module ppm_frame_decoder #(
    parameter int MAX_CHANNELS = ppmfd_pkg::DEF_MAX_CHANNELS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [ppmfd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // edge words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // [15:0] edge_time
    input  logic                               s_tuser,   // [0] capture_overflow
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [3:0] channel_index, [19:4] channel_value, [24:20] locked_channels,
    // [40:25] frame_ticks, [42:41] phase_now, [47:43] zero
    output logic [47:0]                        m_tdata,
    output logic                               m_tuser,   // [0] publish
    output logic                               m_tlast
);
    import ppmfd_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    // channel store write, front -> back
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [TIME_W-1:0] mem_wdata;

    // job queue
    job_t              push_job, head_job;
    logic              job_push, job_pop;
    logic              queue_full, queue_empty;
    logic              run_done;

    // emitter outputs
    logic              out_publish, out_last;
    logic [IDX_W-1:0]  out_index;
    logic [TIME_W-1:0] out_value, out_frame_ticks;
    logic [LOCK_W-1:0] out_locked;
    logic [1:0]        out_phase;

    // Front: one edge word per cycle while not stalled, every decision made at accept time.
    // It stalls while a published run is still reading the channel store,
    // so the store is never rewritten under the emitter.
    ppmfd_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .edge_time        (s_tdata[TIME_W-1:0]),
        .capture_overflow (s_tuser),
        .mem_we           (mem_we),
        .mem_addr         (mem_addr),
        .mem_wdata        (mem_wdata),
        .job_push         (job_push),
        .job              (push_job),
        .queue_full       (queue_full),
        .run_done         (run_done)
    );

    // Short job queue decouples classification from result delivery.
    ppmfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (queue_empty)
    );

    // Back: turns each job into one status word or a run of channel words.
    ppmfd_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .mem_we          (mem_we),
        .mem_addr        (mem_addr),
        .mem_wdata       (mem_wdata),
        .head_job        (head_job),
        .queue_empty     (queue_empty),
        .job_pop         (job_pop),
        .run_done        (run_done),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_publish     (out_publish),
        .out_last        (out_last),
        .out_index       (out_index),
        .out_value       (out_value),
        .out_locked      (out_locked),
        .out_frame_ticks (out_frame_ticks),
        .out_phase       (out_phase)
    );

    assign m_tdata = {5'd0, out_phase, out_frame_ticks, out_locked, out_value, out_index};
    assign m_tuser = out_publish;
    assign m_tlast = out_last;

endmodule

// ===== dv/ppm_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_frame_checker
// Watches the config port and both streams of the PPM frame decoder, decodes
// every accepted edge word with its own copy of the decoder state, queues the
// result words that edge must produce and compares each accepted result word
// field by field against the oldest one queued.
// ----------------------------------------------------------------------------
module ppm_frame_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [ppmfd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ppmfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [15:0]                      s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [47:0]                      m_tdata,
    input  logic                             m_tuser,
    input  logic                             m_tlast,
    output int                               mismatches,
    output int                               backlog,
    output int                               words_checked,
    output int                               channels_checked
);
    import ppmfd_pkg::*;

    localparam int CHANNELS   = DEF_MAX_CHANNELS;
    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic                publish;
        logic [IDX_W-1:0]    chan;
        logic [TIME_W-1:0]   value;
        logic                last;
        logic [LOCK_W-1:0]   locked;
        logic [TIME_W-1:0]   ticks;
        phase_t              phase;
        logic [4:0]          pad;
    } result_word_t;

    result_word_t expected_words[$];

    // register copies
    logic [TIME_W-1:0]   gap_min, pw_lo, pw_hi, cv_lo, cv_hi;
    logic [LOCK_W-1:0]   ch_min;
    logic [SETTLE_W-1:0] lock_n;

    // decoder state copy
    phase_t              ph;
    logic [TIME_W-1:0]   last_edge_t, mark_t, origin_t, frame_t;
    logic [LOCK_W-1:0]   chan_cnt, lock_cnt, cand_cnt;
    logic [SETTLE_W-1:0] settle_cnt;
    logic [TIME_W-1:0]   chan_buf [CHANNELS];

    task automatic push_word(input logic pub, input logic [IDX_W-1:0] chan,
                             input logic [TIME_W-1:0] value, input logic last);
        result_word_t wd;
        wd.publish = pub;
        wd.chan    = chan;
        wd.value   = value;
        wd.last    = last;
        wd.locked  = lock_cnt;
        wd.ticks   = frame_t;
        wd.phase   = ph;
        wd.pad     = 5'd0;
        expected_words.push_back(wd);
    endtask

    task automatic lose_sync();
        ph       = PH_UNSYNC;
        lock_cnt = '0;
        push_word(1'b0, '0, '0, 1'b1);
    endtask

    task automatic decode_edge(input logic [TIME_W-1:0] t, input logic missed);
        logic [TIME_W-1:0] gap, span;
        logic [LOCK_W-1:0] n;
        logic              emit;
        int                i;
        if (missed) begin
            lose_sync();
            return;
        end
        gap = t - last_edge_t;
        if (gap >= gap_min) begin
            // frame start: settle the channel count, maybe publish the frame
            n    = chan_cnt;
            emit = 1'b0;
            if (n != lock_cnt) begin
                if (cand_cnt != n) begin
                    cand_cnt   = n;
                    settle_cnt = lock_n;
                end else if (settle_cnt != '0) begin
                    settle_cnt = settle_cnt - 4'd1;
                end else begin
                    lock_cnt = cand_cnt;
                    cand_cnt = '0;
                end
            end else if (n > ch_min) begin
                emit = 1'b1;
            end
            chan_cnt    = '0;
            ph          = PH_ARM;
            last_edge_t = t;
            if (!emit) begin
                push_word(1'b0, '0, '0, 1'b1);
            end else begin
                for (i = 0; i < int'(n); i++)
                    push_word(1'b1, i[IDX_W-1:0], chan_buf[i], i + 1 == int'(n));
            end
            return;
        end
        case (ph)
            PH_ARM: begin
                if (gap < pw_lo || gap > pw_hi) begin
                    lose_sync();
                    return;
                end
                mark_t   = last_edge_t;
                frame_t  = last_edge_t - origin_t;
                origin_t = last_edge_t;
                ph       = PH_ACTIVE;
            end
            PH_INACTIVE: begin
                if (gap < pw_lo || gap > pw_hi) begin
                    lose_sync();
                    return;
                end
                ph = PH_ACTIVE;
            end
            PH_ACTIVE: begin
                span   = t - mark_t;
                mark_t = t;
                if (span < cv_lo || span > cv_hi) begin
                    lose_sync();
                    return;
                end
                // intervals past a full store are checked but dropped
                if (chan_cnt < CHANNELS) begin
                    chan_buf[chan_cnt[IDX_W-1:0]] = span;
                    chan_cnt = chan_cnt + 5'd1;
                end
                ph = PH_INACTIVE;
            end
            default: ;
        endcase
        last_edge_t = t;
        push_word(1'b0, '0, '0, 1'b1);
    endtask

    task automatic check_word();
        result_word_t got, want;
        got = {m_tuser, m_tdata[3:0], m_tdata[19:4], m_tlast, m_tdata[24:20],
               m_tdata[40:25], m_tdata[42:41], m_tdata[47:43]};
        words_checked++;
        if (got.publish === 1'b1)
            channels_checked++;
        if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("[%0t] unexpected result word: pub=%0d ch=%0d val=%0d last=%0d",
                         $time, got.publish, got.chan, got.value, got.last);
            return;
        end
        want = expected_words.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_CAP) begin
                $display("[%0t] result word mismatch", $time);
                $display("    expected pub=%0d ch=%0d val=%0d last=%0d lock=%0d ticks=%0d ph=%0d pad=%0d",
                         want.publish, want.chan, want.value, want.last, want.locked,
                         want.ticks, want.phase, want.pad);
                $display("    actual   pub=%0d ch=%0d val=%0d last=%0d lock=%0d ticks=%0d ph=%0d pad=%0d",
                         got.publish, got.chan, got.value, got.last, got.locked,
                         got.ticks, got.phase, got.pad);
            end
            if (mismatches == REPORT_CAP)
                $display("[%0t] mismatch report limit hit, counting only", $time);
        end
    endtask

    initial begin
        mismatches       = 0;
        backlog          = 0;
        words_checked    = 0;
        channels_checked = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            gap_min     = RST_START_GAP_MIN;
            pw_lo       = RST_PULSE_WIDTH_MIN;
            pw_hi       = RST_PULSE_WIDTH_MAX;
            cv_lo       = RST_CHANNEL_VALUE_MIN;
            cv_hi       = RST_CHANNEL_VALUE_MAX;
            ch_min      = RST_MIN_CHANNELS;
            lock_n      = RST_LOCK_FRAMES;
            ph          = PH_UNSYNC;
            last_edge_t = '0;
            mark_t      = '0;
            origin_t    = '0;
            frame_t     = '0;
            chan_cnt    = '0;
            lock_cnt    = '0;
            cand_cnt    = '0;
            settle_cnt  = '0;
            expected_words.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_START_GAP_MIN:     gap_min = cfg_wdata;
                    REG_PULSE_WIDTH_MIN:   pw_lo   = cfg_wdata;
                    REG_PULSE_WIDTH_MAX:   pw_hi   = cfg_wdata;
                    REG_CHANNEL_VALUE_MIN: cv_lo   = cfg_wdata;
                    REG_CHANNEL_VALUE_MAX: cv_hi   = cfg_wdata;
                    REG_MIN_CHANNELS:      ch_min  = cfg_wdata[LOCK_W-1:0];
                    REG_LOCK_FRAMES:       lock_n  = cfg_wdata[SETTLE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                decode_edge(s_tdata, s_tuser);
            if (m_tvalid && m_tready)
                check_word();
        end
        backlog = expected_words.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the PPM frame decoder. A directed burst walks the
// window edges, wrap-around, missed edges and count changes; then PPM frames
// with random timing, channel counts and occasional flaws run under five
// register settings, with random idling on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import ppmfd_pkg::*;

    // Slowest legal run: every edge word, each giving at most a full store of
    // result words that each wait out the longest receiver stall, plus the
    // longest sender gaps; the limit leaves several times that.
    localparam int LIMIT = 2_000_000;
    // status word delay plus a full 16-channel run
    localparam int TAIL  = 64;

    typedef enum {
        FLAW_NONE,
        FLAW_PULSE,      // one separator pulse outside its window
        FLAW_INTERVAL,   // one channel interval outside its window
        FLAW_MISSED,     // capture overflow in the middle of the frame
        FLAW_STRAY,      // random extra word, random overflow flag
        FLAW_SHORT_GAP   // frame gap one tick short of a start
    } flaw_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [47:0]           m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int mismatches, backlog, words_checked, channels_checked;

    // register mirror, used only to shape legal frames
    int cfg_gap, cfg_pw_lo, cfg_pw_hi, cfg_cv_lo, cfg_cv_hi;

    logic [15:0] edge_clk;     // capture time of the last edge sent without the overflow flag
    int          sent     = 0;
    int          settings = 1;
    int          pauses   = 0;
    logic        tx_steady = 1'b0;

    int   cycles  = 0;
    int   rx_hold = 0;
    int   rx_age  = 0;
    int   rx_roll;
    logic rx_steady = 1'b0;

    always #6 aclk = ~aclk;

    ppm_frame_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    ppm_frame_checker i_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .mismatches       (mismatches),
        .backlog          (backlog),
        .words_checked    (words_checked),
        .channels_checked (channels_checked)
    );

    // Receiver back-pressure: mostly short stalls, a few long ones, and
    // stretches of always-ready, chosen at random.
    always @(negedge aclk) begin
        rx_age = rx_age + 1;
        if (rx_age % 256 == 0)
            rx_steady = ($urandom_range(0, 3) == 0);
        if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_tready <= 1'b1;
            end else if (rx_roll < 96) begin
                m_tready <= 1'b0;
                rx_hold = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                rx_hold = $urandom_range(15, 40);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random value in [lo, hi], ends favored; anything at all when empty
    function automatic int pick_in(input int lo, input int hi);
        int r;
        if (lo > hi)
            return $urandom_range(0, 65535);
        r = $urandom_range(0, 7);
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return $urandom_range(lo, hi);
    endfunction

    // Called at a falling edge; returns at the falling edge after the word
    // is taken. tvalid is left high so back-to-back words need no toggle.
    task automatic send_edge(input logic [15:0] t, input logic missed);
        int gap;
        gap = tx_steady ? 0 : idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        s_tuser  <= missed;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        sent++;
        if (!missed)
            edge_clk = t;
    endtask

    // hold the sender until every queued result word has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (backlog != 0);
        pauses++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
    endtask

    task automatic set_regs(input int gap, input int pw_lo, input int pw_hi,
                            input int cv_lo, input int cv_hi,
                            input int ch_min, input int lock_n);
        write_reg(REG_START_GAP_MIN, gap);
        write_reg(REG_PULSE_WIDTH_MIN, pw_lo);
        write_reg(REG_PULSE_WIDTH_MAX, pw_hi);
        write_reg(REG_CHANNEL_VALUE_MIN, cv_lo);
        write_reg(REG_CHANNEL_VALUE_MAX, cv_hi);
        write_reg(REG_MIN_CHANNELS, ch_min);
        write_reg(REG_LOCK_FRAMES, lock_n);
        cfg_we    <= 1'b0;
        cfg_gap   = gap;
        cfg_pw_lo = pw_lo;
        cfg_pw_hi = pw_hi;
        cfg_cv_lo = cv_lo;
        cfg_cv_hi = cv_hi;
        settings++;
    endtask

    // One PPM frame: start gap, then per channel a separator edge and a
    // channel edge, both timed from the previous mark. Pulse widths stay
    // below the start gap and so does the rest of each channel slot.
    task automatic send_frame(input int n, input flaw_t flaw);
        logic [15:0] mark, junk;
        int          w, c, g, k, spot, r;
        spot = $urandom_range(0, n - 1);
        if (flaw == FLAW_SHORT_GAP && cfg_gap > 0)
            g = cfg_gap - 1;
        else
            g = pick_in(cfg_gap, (cfg_gap + 3000 > 65535) ? 65535 : cfg_gap + 3000);
        send_edge(edge_clk + g[15:0], 1'b0);
        mark = edge_clk;
        for (k = 0; k < n; k++) begin
            w = pick_in(cfg_pw_lo, (cfg_pw_hi < cfg_gap - 1) ? cfg_pw_hi : cfg_gap - 1);
            c = pick_in((cfg_cv_lo > w) ? cfg_cv_lo : w,
                        (cfg_cv_hi < w + cfg_gap - 1) ? cfg_cv_hi : w + cfg_gap - 1);
            if (k == spot) begin
                r    = $urandom;
                junk = r[15:0];
                case (flaw)
                    FLAW_PULSE: begin
                        if (cfg_pw_lo > 0 && r[16])
                            w = $urandom_range(0, cfg_pw_lo - 1);
                        else if (cfg_pw_hi < 65535)
                            w = cfg_pw_hi + 1 + $urandom_range(0, 30);
                    end
                    FLAW_INTERVAL: begin
                        if (cfg_cv_lo > 0 && r[16])
                            c = $urandom_range(0, cfg_cv_lo - 1);
                        else if (cfg_cv_hi < 65535)
                            c = cfg_cv_hi + 1 + $urandom_range(0, 30);
                    end
                    FLAW_MISSED: send_edge(junk, 1'b1);
                    FLAW_STRAY:  send_edge(junk, r[17]);
                    default: ;
                endcase
            end
            send_edge(mark + w[15:0], 1'b0);
            send_edge(mark + c[15:0], 1'b0);
            mark = mark + c[15:0];
        end
    endtask

    // Mostly clean frames with a sticky channel count so the lock can form
    // and frames get published; the rest carry one flaw each.
    task automatic run_frames(input int budget, input int n_lo, input int n_hi);
        int    goal, n, r;
        flaw_t flaw;
        goal = sent + budget;
        n    = $urandom_range(n_lo, n_hi);
        while (sent < goal) begin
            if ($urandom_range(0, 6) == 0)
                n = $urandom_range(n_lo, n_hi);
            tx_steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 78)
                flaw = FLAW_NONE;
            else if (r < 82)
                flaw = FLAW_PULSE;
            else if (r < 86)
                flaw = FLAW_INTERVAL;
            else if (r < 90)
                flaw = FLAW_MISSED;
            else if (r < 95)
                flaw = FLAW_STRAY;
            else
                flaw = FLAW_SHORT_GAP;
            if ($urandom_range(0, 11) == 0)
                drain();
            send_frame(n, flaw);
        end
        tx_steady = 1'b0;
    endtask

    initial begin
        cfg_gap   = RST_START_GAP_MIN;
        cfg_pw_lo = RST_PULSE_WIDTH_MIN;
        cfg_pw_hi = RST_PULSE_WIDTH_MAX;
        cfg_cv_lo = RST_CHANNEL_VALUE_MIN;
        cfg_cv_hi = RST_CHANNEL_VALUE_MAX;
        edge_clk  = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed burst on reset register values
        send_edge(16'd0, 1'b0);        // unsynchronised: only the edge time moves
        send_edge(16'd100, 1'b0);
        send_edge(16'hFFFF, 1'b0);     // start at the top of the counter
        send_edge(16'd299, 1'b0);      // pulse across the wrap, full-range frame length
        send_edge(16'd999, 1'b0);      // channel 1000
        send_edge(16'd1198, 1'b0);     // pulse 199: just below window
        send_edge(16'd3299, 1'b0);     // gap exactly at threshold, new count candidate
        send_edge(16'd3899, 1'b0);     // pulse at window max
        send_edge(16'd5499, 1'b0);     // channel at window max
        send_edge(16'd5699, 1'b0);     // pulse at window min
        send_edge(16'd6299, 1'b0);     // channel at window min
        send_edge(16'd6900, 1'b0);     // pulse 601: just above window
        send_edge(16'h8000, 1'b1);     // missed edge
        send_edge(16'd8598, 1'b0);     // gap one short of a start
        send_edge(16'd10898, 1'b0);    // start, candidate replaced by count 2
        send_edge(16'd11298, 1'b0);
        send_edge(16'd13099, 1'b0);    // channel 2201: just above window
        send_edge(16'd15399, 1'b0);    // start with no channels, equal to the locked count: settling untouched
        send_edge(16'd15799, 1'b0);
        send_edge(16'd16198, 1'b0);    // channel 799: just below window
        send_edge(16'h7FFF, 1'b1);
        send_edge(16'hFFFF, 1'b0);

        run_frames(90, 6, 8);
        drain();
        set_regs(3000, 100, 700, 700, 2900, 0, 1);
        run_frames(80, 1, 4);
        drain();
        // long frames overflow the 16-entry store
        set_regs(1500, 50, 300, 400, 1400, 2, 0);
        run_frames(140, 15, 17);
        drain();
        set_regs(65535, 0, 65535, 0, 65535, 16, 15);
        run_frames(50, 1, 3);
        drain();
        // every edge is a frame start, windows empty
        set_regs(0, 65535, 0, 65535, 0, 0, 1);
        run_frames(30, 1, 2);
        drain();
        repeat (TAIL) @(negedge aclk);

        $display("Sent %0d edge words under %0d register settings, %0d sender holds.",
                 sent, settings, pauses);
        $display("Checked %0d result words, %0d of them published channel values.",
                 words_checked, channels_checked);
        if (mismatches == 0 && backlog == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatching words, %0d result words never seen",
                     mismatches, backlog);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
